// ===== rtl/assert_macros.svh =====
// Shared assertion macros. Each checks on the rising edge of clk and is
// held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rflk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rflk_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CODE_W     = 4;
  localparam int RX_W       = 32;
  localparam int NOW_W      = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ROLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES = 2'd2;

  localparam logic [15:0] POLL_PERIOD_RST = 16'd1000;
  localparam logic [7:0]  MAX_TRIES_RST   = 8'd3;

  // Radio code words
  localparam logic [CODE_W-1:0] CODE_NONE     = 4'd0;
  localparam logic [CODE_W-1:0] CODE_HELLO_M  = 4'd5;
  localparam logic [CODE_W-1:0] CODE_HELLO_S  = 4'd6;
  localparam logic [CODE_W-1:0] CODE_AREUOK   = 4'd7;
  localparam logic [CODE_W-1:0] CODE_IMOK     = 4'd8;
  localparam logic [CODE_W-1:0] CODE_STILL    = 4'd9;
  localparam logic [CODE_W-1:0] CODE_IAMHERE  = 4'd10;

  typedef enum logic [2:0] {
    ST_SEARCHING = 3'd0,
    ST_FOUND     = 3'd1,
    ST_CONNECTED = 3'd2,
    ST_MAYLOST   = 3'd3,
    ST_LOST      = 3'd4
  } status_t;

  typedef struct packed {
    logic        slave_role;
    logic [15:0] poll_period_ms;
    logic [7:0]  max_tries;
  } cfg_t;

  typedef struct packed {
    status_t           link_status;
    logic [CODE_W-1:0] send_code;
    logic              rx_consumed;
  } step_out_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rflk_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rflk_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] now_ms;
  logic [31:0] rx_code;

  modport source (output valid, action, now_ms, rx_code, input ready);
  modport sink (input valid, action, now_ms, rx_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/rflk_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rflk_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] link_status;
  logic       send_valid;
  logic [3:0] send_code;
  logic       rx_consumed;

  modport source (output valid, link_status, send_valid, send_code, rx_consumed,
                  input ready);
  modport sink (input valid, link_status, send_valid, send_code, rx_consumed,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/rflk_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rflk_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [rflk_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [rflk_pkg::CFG_DATA_W-1:0] wr_data,
  output rflk_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_role     <= 1'b0;
      cfg.poll_period_ms <= rflk_pkg::POLL_PERIOD_RST;
      cfg.max_tries      <= rflk_pkg::MAX_TRIES_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        rflk_pkg::CFG_SLAVE_ROLE:  cfg.slave_role     <= wr_data[0];
        rflk_pkg::CFG_POLL_PERIOD: cfg.poll_period_ms <= wr_data[15:0];
        rflk_pkg::CFG_MAX_TRIES:   cfg.max_tries      <= wr_data[7:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rflk_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rflk_step #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step_en,
  input  wire rflk_pkg::cfg_t             cfg,
  input  wire logic                       action,
  input  wire logic [rflk_pkg::NOW_W-1:0] now_ms,
  input  wire logic [rflk_pkg::RX_W-1:0]  rx_code,
  output rflk_pkg::step_out_t             step_out
);

  // Compare width: covers elapsed time and the 24-bit lost threshold
  localparam int LW = (TIME_BITS > 24) ? TIME_BITS : 24;

  rflk_pkg::status_t      status, status_next;
  logic [7:0]             try_count, try_next;
  logic [TIME_BITS-1:0]   last_poll_time, last_next;

  logic [rflk_pkg::RX_W-1:0]   rx;
  logic [TIME_BITS-1:0]        now_t, elapsed, period_t;
  logic [23:0]                 lost_lim;
  logic [16:0]                 may_lim;
  logic                        slave_code, master_code;
  logic [rflk_pkg::CODE_W-1:0] send;
  logic                        consumed;

  assign rx       = action ? rx_code : '0;
  assign now_t    = TIME_BITS'(now_ms);
  assign elapsed  = now_t - last_poll_time;
  assign period_t = TIME_BITS'(cfg.poll_period_ms);
  assign lost_lim = 24'(cfg.poll_period_ms) * 24'(cfg.max_tries);
  assign may_lim  = 17'(cfg.poll_period_ms) + 17'(cfg.poll_period_ms[15:1]);

  assign slave_code  = (rx == 32'(rflk_pkg::CODE_HELLO_S)) ||
                       (rx == 32'(rflk_pkg::CODE_IMOK)) ||
                       (rx == 32'(rflk_pkg::CODE_IAMHERE));
  assign master_code = (rx == 32'(rflk_pkg::CODE_HELLO_M)) ||
                       (rx == 32'(rflk_pkg::CODE_AREUOK)) ||
                       (rx == 32'(rflk_pkg::CODE_STILL));

  always_comb begin
    status_next = status;
    try_next    = try_count;
    last_next   = last_poll_time;
    send        = rflk_pkg::CODE_NONE;
    consumed    = 1'b0;
    if (!cfg.slave_role) begin
      if (slave_code) begin
        consumed = 1'b1;
        try_next = '0;
      end
      if (slave_code || (elapsed > period_t)) begin
        last_next = now_t;
        if (status != rflk_pkg::ST_CONNECTED && status != rflk_pkg::ST_MAYLOST) begin
          // handshake phase
          if (rx == 32'(rflk_pkg::CODE_HELLO_S)) begin
            status_next = rflk_pkg::ST_FOUND;
            send        = rflk_pkg::CODE_AREUOK;
            try_next    = rflk_pkg::sat_inc(try_next);
          end else if (rx == 32'(rflk_pkg::CODE_IMOK)) begin
            status_next = rflk_pkg::ST_CONNECTED;
          end else begin
            send     = rflk_pkg::CODE_HELLO_M;
            try_next = rflk_pkg::sat_inc(try_next);
          end
        end else if (rx != 32'(rflk_pkg::CODE_IAMHERE)) begin
          // keepalive probe, or give up once tries run out
          if (try_next < cfg.max_tries) begin
            send     = rflk_pkg::CODE_STILL;
            try_next = rflk_pkg::sat_inc(try_next);
            if (try_next == 8'd1) begin
              status_next = rflk_pkg::ST_CONNECTED;
            end else if (try_next == 8'd2) begin
              status_next = rflk_pkg::ST_MAYLOST;
            end
          end else begin
            status_next = rflk_pkg::ST_LOST;
          end
        end else begin
          try_next    = '0;
          status_next = rflk_pkg::ST_CONNECTED;
        end
      end
    end else begin
      if (master_code) begin
        consumed = 1'b1;
        try_next = '0;
      end
      if (rx == 32'(rflk_pkg::CODE_HELLO_M)) begin
        send        = rflk_pkg::CODE_HELLO_S;
        status_next = rflk_pkg::ST_FOUND;
        last_next   = now_t;
      end else if (rx == 32'(rflk_pkg::CODE_AREUOK)) begin
        send        = rflk_pkg::CODE_IMOK;
        status_next = rflk_pkg::ST_CONNECTED;
        last_next   = now_t;
      end else if (rx == 32'(rflk_pkg::CODE_STILL)) begin
        send        = rflk_pkg::CODE_IAMHERE;
        status_next = rflk_pkg::ST_CONNECTED;
        last_next   = now_t;
      end else if (LW'(elapsed) > LW'(lost_lim)) begin
        status_next = rflk_pkg::ST_LOST;
        last_next   = now_t;
      end else if (LW'(elapsed) > LW'(may_lim)) begin
        status_next = rflk_pkg::ST_MAYLOST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status         <= rflk_pkg::ST_SEARCHING;
      try_count      <= '0;
      last_poll_time <= '0;
    end else if (step_en) begin
      status         <= status_next;
      try_count      <= try_next;
      last_poll_time <= last_next;
    end
  end

  assign step_out.link_status = status_next;
  assign step_out.send_code   = send;
  assign step_out.rx_consumed = consumed;

endmodule

`default_nettype wire

// ===== rtl/rf_link_keepalive_handshake_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Fields
// poll     in   action, now_ms, rx_code
// result   out  link_status, send_valid, send_code, rx_consumed
//
// One poll word per cycle while the result register is empty or taken;
// each word passes the input register, then the result register.
// rst (synchronous, active high) clears status to searching, tries and
// poll time to zero, and restores register defaults.
// A stalled result holds its register; poll.ready drops only when both the
// input and result registers are full and the result is not taken.

module rf_link_keepalive_handshake_top #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  rflk_in_if.sink                              poll,
  rflk_out_if.source                           result,
  input  wire logic                            wr_en,
  input  wire logic [rflk_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [rflk_pkg::CFG_DATA_W-1:0] wr_data
);

  rflk_pkg::cfg_t      cfg;
  rflk_pkg::step_out_t step_out;

  logic        s1_valid;
  logic        s1_action;
  logic [31:0] s1_now;
  logic [31:0] s1_rx;
  logic        s1_go;

  logic                out_valid;
  rflk_pkg::step_out_t out_word;

  assign s1_go      = s1_valid && (!out_valid || result.ready);
  assign poll.ready = !s1_valid || s1_go;

  rflk_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  rflk_step #(.TIME_BITS(TIME_BITS)) u_step (
    .clk      (clk),
    .rst      (rst),
    .step_en  (s1_go),
    .cfg      (cfg),
    .action   (s1_action),
    .now_ms   (s1_now),
    .rx_code  (s1_rx),
    .step_out (step_out)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_action <= poll.action;
      s1_now    <= poll.now_ms;
      s1_rx     <= poll.rx_code;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_word <= step_out;
    end
  end

  assign result.valid       = out_valid;
  assign result.link_status = out_word.link_status;
  assign result.send_code   = out_word.send_code;
  assign result.send_valid  = (out_word.send_code != rflk_pkg::CODE_NONE);
  assign result.rx_consumed = out_word.rx_consumed;

`include "assert_macros.svh"

  // a slave only transmits in answer to a master code it consumed
  `ASSERT_SAME(a_slave_reply_consumed, s1_go && cfg.slave_role && (step_out.send_code != rflk_pkg::CODE_NONE), step_out.rx_consumed)
  // are-you-ok is only sent on a consumed slave hello
  `ASSERT_SAME(a_areuok_consumed, out_valid && (out_word.send_code == rflk_pkg::CODE_AREUOK), out_word.rx_consumed)
  // a stalled input word stays in the input register
  `ASSERT_NEXT(a_s1_hold, s1_valid && !s1_go, s1_valid && $stable(s1_now) && $stable(s1_rx))

endmodule

`default_nettype wire
